FILE: rtl/wpf_pkg.sv
`default_nettype none
package wpf_pkg;
   localparam int MaxWaypoints = 16;
   localparam int IdxW = $clog2(MaxWaypoints);
   localparam int CntW = $clog2(MaxWaypoints + 1);
   localparam int CoordW = 24;
   localparam int PointW = 3 * CoordW;
   localparam int DiffW = 25;
   localparam int SumW = 51;
   localparam int RootW = 26;
   localparam int NumW = 45;
   localparam int QuoW = 45;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_START = 2'd2;
   localparam logic [1:0] ACT_TICK = 2'd3;

   localparam logic [15:0] SPEED_RESET = 16'd256;
   localparam logic signed [CoordW-1:0] MAX24 = 24'sh7FFFFF;
   localparam logic signed [CoordW-1:0] MIN24 = -24'sh800000;

   typedef logic [CntW-1:0] count_type;

   typedef struct packed {
      logic load_diff;
      logic sq_step;
      logic sqrt_start;
      logic sqrt_step;
      logic div_start;
      logic div_step;
      logic [1:0] axis;
      logic apply_step;
      logic snap;
      logic load_cur_mem;
      logic load_tgt_mem;
   } dp_cmd_type;

   typedef struct packed {
      logic near;
      logic at_target;
   } dp_status_type;
endpackage
`default_nettype wire

FILE: rtl/wpf_stream_if.sv
`default_nettype none
interface wpf_stream_if #(parameter int W = 1);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/wpf_ram.sv
`default_nettype none
module wpf_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] wr_addr,
   input wire logic [Width-1:0] wr_data,
   input wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/wpf_datapath.sv
`default_nettype none
module wpf_datapath
   import wpf_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire dp_cmd_type cmd,
   input wire logic [15:0] speed,
   input wire logic [PointW-1:0] mem_data,
   output dp_status_type status,
   output logic [PointW-1:0] cur_point
);
   logic signed [CoordW-1:0] cur_ff [3];
   logic signed [CoordW-1:0] tgt_ff [3];
   logic signed [DiffW-1:0] d_ff [3];
   logic [SumW-1:0] sum_ff;
   logic [1:0] sq_cnt_ff;
   logic [SumW-1:0] rem_ff;
   logic [RootW-1:0] root_ff;
   logic [2*RootW-1:0] src_ff;
   logic [NumW-1:0] num_ff;
   logic [NumW-1:0] drem_ff;
   logic [QuoW-1:0] quo_ff;

   logic [DiffW-1:0] mag [3];
   logic [SumW-1:0] sq;
   logic [SumW-1:0] rem_sh;
   logic [SumW:0] trial;
   logic [NumW:0] dtrial;
   logic signed [CoordW+1:0] nsum;
   logic signed [QuoW:0] st;
   logic signed [QuoW+1:0] wide;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag[k] = d_ff[k][DiffW-1] ? DiffW'(-d_ff[k]) : d_ff[k];
      end
      sq = SumW'(mag[sq_cnt_ff]) * SumW'(mag[sq_cnt_ff]);
      rem_sh = {rem_ff[SumW-3:0], src_ff[2*RootW-1 -: 2]};
      trial = {1'b0, rem_sh} - {1'b0, SumW'({root_ff, 2'b01})};
      dtrial = {drem_ff, num_ff[NumW-1]} - {1'b0, NumW'(root_ff)};
      st = d_ff[cmd.axis][DiffW-1] ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      wide = (QuoW+2)'(cur_ff[cmd.axis]) + (QuoW+2)'(st);
      nsum = '0;
      if (wide > (QuoW+2)'(MAX24)) nsum = (CoordW+2)'(MAX24);
      else if (wide < (QuoW+2)'(MIN24)) nsum = (CoordW+2)'(MIN24);
      else nsum = (CoordW+2)'(wide);
   end

   // Square root consumes two bits of the sum per step, division one bit per step.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            cur_ff[k] <= '0;
            tgt_ff[k] <= '0;
         end
         sq_cnt_ff <= '0;
      end else begin
         if (cmd.load_diff) begin
            for (int k = 0; k < 3; k++) begin
               d_ff[k] <= DiffW'(tgt_ff[k]) - DiffW'(cur_ff[k]);
            end
            sum_ff <= '0;
            sq_cnt_ff <= '0;
         end
         if (cmd.sq_step) begin
            sum_ff <= sum_ff + sq;
            sq_cnt_ff <= sq_cnt_ff + 2'd1;
         end
         if (cmd.sqrt_start) begin
            rem_ff <= '0;
            root_ff <= '0;
            src_ff <= {1'b0, sum_ff};
         end
         if (cmd.sqrt_step) begin
            if (!trial[SumW]) rem_ff <= SumW'(trial);
            else rem_ff <= rem_sh;
            root_ff <= {root_ff[RootW-2:0], ~trial[SumW]};
            src_ff <= {src_ff[2*RootW-3:0], 2'b00};
         end
         if (cmd.div_start) begin
            num_ff <= NumW'(mag[cmd.axis]) * NumW'({speed, 4'b0000});
            drem_ff <= '0;
            quo_ff <= '0;
         end
         if (cmd.div_step) begin
            if (!dtrial[NumW]) drem_ff <= NumW'(dtrial);
            else drem_ff <= {drem_ff[NumW-2:0], num_ff[NumW-1]};
            quo_ff <= {quo_ff[QuoW-2:0], ~dtrial[NumW]};
            num_ff <= {num_ff[NumW-2:0], 1'b0};
         end
         if (cmd.apply_step) cur_ff[cmd.axis] <= CoordW'(nsum);
         if (cmd.snap) begin
            for (int k = 0; k < 3; k++) cur_ff[k] <= tgt_ff[k];
         end
         if (cmd.load_cur_mem) begin
            for (int k = 0; k < 3; k++) cur_ff[k] <= mem_data[CoordW*k +: CoordW];
         end
         if (cmd.load_tgt_mem) begin
            for (int k = 0; k < 3; k++) tgt_ff[k] <= mem_data[CoordW*k +: CoordW];
         end
      end
   end

   assign status.near = sum_ff < SumW'(1 << 24);
   assign status.at_target = cur_ff[0] == tgt_ff[0] && cur_ff[1] == tgt_ff[1]
      && cur_ff[2] == tgt_ff[2];
   assign cur_point = {cur_ff[2], cur_ff[1], cur_ff[0]};
endmodule
`default_nettype wire

FILE: rtl/wpf_control.sv
`default_nettype none
module wpf_control
   import wpf_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire logic [1:0] in_action,
   input wire logic [PointW-1:0] in_point,
   output logic out_valid,
   input wire logic out_ready,
   output logic out_done,
   output logic out_full,
   input wire dp_status_type status,
   output dp_cmd_type cmd,
   output logic mem_we,
   output logic [IdxW-1:0] mem_waddr,
   output logic [PointW-1:0] mem_wdata,
   output logic [IdxW-1:0] mem_raddr
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD0 = 4'd1;
   localparam logic [3:0] S_RD1 = 4'd2;
   localparam logic [3:0] S_RD2 = 4'd3;
   localparam logic [3:0] S_SQ = 4'd4;
   localparam logic [3:0] S_CHK = 4'd5;
   localparam logic [3:0] S_SQRT = 4'd6;
   localparam logic [3:0] S_DIVI = 4'd7;
   localparam logic [3:0] S_DIV = 4'd8;
   localparam logic [3:0] S_APPLY = 4'd9;
   localparam logic [3:0] S_ARRIVE = 4'd10;
   localparam logic [3:0] S_NEXT = 4'd11;
   localparam logic [3:0] S_OUT = 4'd12;

   logic [3:0] state_ff, state_in;
   count_type count_ff, next_ff;
   logic ended_ff, running_ff, full_ff, start1_ff;
   logic [5:0] iter_ff;
   logic [1:0] axis_ff;
   logic out_valid_ff;

   assign in_ready = state_ff == S_IDLE && !out_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_done = ended_ff;
   assign out_full = full_ff;
   assign mem_we = in_valid && in_ready && in_action == ACT_APPEND
      && count_ff < count_type'(MaxWaypoints);
   assign mem_waddr = IdxW'(count_ff);
   assign mem_wdata = in_point;

   always_comb begin
      cmd = '0;
      cmd.axis = axis_ff;
      mem_raddr = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            mem_raddr = '0;
            if (in_valid && in_ready) begin
               if (in_action == ACT_START && count_ff != '0) state_in = S_RD0;
               else if (in_action == ACT_TICK && running_ff && !ended_ff) begin
                  cmd.load_diff = 1'b1;
                  state_in = S_SQ;
               end
            end
         end
         S_RD0: begin
            mem_raddr = start1_ff ? IdxW'(0) : IdxW'(1);
            cmd.load_cur_mem = 1'b1;
            cmd.load_tgt_mem = start1_ff;
            state_in = start1_ff ? S_IDLE : S_RD1;
         end
         S_RD1: begin
            mem_raddr = IdxW'(1);
            state_in = S_RD2;
         end
         S_RD2: begin
            cmd.load_tgt_mem = 1'b1;
            state_in = S_IDLE;
         end
         S_SQ: begin
            cmd.sq_step = 1'b1;
            if (iter_ff == 6'd2) state_in = S_CHK;
         end
         S_CHK: begin
            if (status.near) begin
               cmd.snap = 1'b1;
               state_in = S_ARRIVE;
            end else begin
               cmd.sqrt_start = 1'b1;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (iter_ff == 6'd25) state_in = S_DIVI;
         end
         S_DIVI: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (iter_ff == 6'(QuoW - 1)) state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply_step = 1'b1;
            state_in = axis_ff == 2'd2 ? S_ARRIVE : S_DIVI;
         end
         S_ARRIVE: begin
            mem_raddr = IdxW'(next_ff);
            if (status.at_target && next_ff < count_ff) state_in = S_NEXT;
            else state_in = S_IDLE;
         end
         S_NEXT: begin
            mem_raddr = IdxW'(next_ff);
            cmd.load_tgt_mem = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         next_ff <= '0;
         ended_ff <= 1'b0;
         running_ff <= 1'b0;
         full_ff <= 1'b0;
         start1_ff <= 1'b0;
         iter_ff <= '0;
         axis_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff <= (state_in != state_ff) ? '0 : iter_ff + 6'd1;
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         if (state_ff != S_IDLE && state_in == S_IDLE) out_valid_ff <= 1'b1;
         if (state_ff == S_APPLY) axis_ff <= axis_ff + 2'd1;
         if (state_ff == S_ARRIVE) begin
            axis_ff <= '0;
            if (status.at_target) begin
               if (next_ff < count_ff) next_ff <= next_ff + 1'b1;
               else begin
                  ended_ff <= 1'b1;
                  running_ff <= 1'b0;
               end
            end
         end
         if (in_valid && in_ready) begin
            full_ff <= in_action == ACT_APPEND && count_ff == count_type'(MaxWaypoints);
            case (in_action)
               ACT_CLEAR: begin
                  count_ff <= '0;
                  next_ff <= '0;
                  running_ff <= 1'b0;
                  ended_ff <= 1'b0;
                  out_valid_ff <= 1'b1;
               end
               ACT_APPEND: begin
                  if (count_ff < count_type'(MaxWaypoints)) count_ff <= count_ff + 1'b1;
                  out_valid_ff <= 1'b1;
               end
               ACT_START: begin
                  start1_ff <= count_ff == count_type'(1);
                  if (count_ff >= count_type'(2)) begin
                     next_ff <= count_type'(2);
                     running_ff <= 1'b1;
                     ended_ff <= 1'b0;
                  end else begin
                     next_ff <= count_ff;
                     running_ff <= 1'b0;
                     ended_ff <= 1'b1;
                  end
                  if (count_ff == '0) out_valid_ff <= 1'b1;
               end
               default: begin
                  if (!(running_ff && !ended_ff)) out_valid_ff <= 1'b1;
               end
            endcase
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !in_ready)
      else $error("input taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(MaxWaypoints))
      else $error("count overflow");
   assert property (@(posedge clock) disable iff (reset)
      running_ff |-> !ended_ff)
      else $error("running and ended");
endmodule
`default_nettype wire

FILE: rtl/waypoint_path_follower_top.sv
`default_nettype none
// Channel   Direction  Payload
// req       in         action, point_x, point_y, point_z
// rsp       out        pos_x, pos_y, pos_z, path_done, table_full
// csr       in         step_speed
// Clear, append, an idle tick and a start without waypoints respond in the next cycle.
// A start reads the table in S_RD0, and also in S_RD1 and S_RD2 for two or more waypoints.
// A snapping tick passes S_SQ, S_CHK, S_ARRIVE and, when a waypoint remains, S_NEXT.
// A moving tick runs three squares, a 26-step square root,
// then three 45-step divides on one shared divider, each with a load and an apply state.
// Reset is synchronous and clears all control state and the speed to 1.0.
// A stalled response holds the block; no new request is taken until it transfers.
module waypoint_path_follower_top
   import wpf_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   wpf_stream_if.sink req,
   wpf_stream_if.source rsp,
   wpf_stream_if.sink csr
);
   dp_cmd_type cmd;
   dp_status_type status;
   logic [15:0] speed_ff;
   logic [PointW-1:0] mem_rdata, cur_point, pos_ff;
   logic start_ff;
   logic mem_we, done, full;
   logic [IdxW-1:0] waddr, raddr;
   logic [PointW-1:0] wdata;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) speed_ff <= SPEED_RESET;
      else if (csr.valid) speed_ff <= csr.data[15:0];
   end

   wpf_ram #(.Width(PointW), .Depth(MaxWaypoints)) u_ram (
      .clock(clock), .wr_en(mem_we), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(mem_rdata));

   wpf_control u_ctl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .in_action(req.data[1:0]), .in_point(req.data[73:2]),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_done(done), .out_full(full),
      .status(status), .cmd(cmd),
      .mem_we(mem_we), .mem_waddr(waddr), .mem_wdata(wdata), .mem_raddr(raddr));

   wpf_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .speed(speed_ff),
      .mem_data(mem_rdata), .status(status), .cur_point(cur_point));

   // The reported point is captured at the request transfer; a start reports the loaded point.
   always_ff @(posedge clock) begin
      if (reset) start_ff <= 1'b0;
      else if (req.valid && req.ready) start_ff <= req.data[1:0] == ACT_START;
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) pos_ff <= cur_point;
   end

   assign rsp.data = {full, done, start_ff ? cur_point : pos_ff};
endmodule
`default_nettype wire
